FILE: sv/wtach_pkg.sv
// Shared types, constants and control structs for the windowed tachometer.
// Used by wtach_ctrl, wtach_dp and windowed_tachometer_core.
package wtach_pkg;

    // Timestamp and period counter widths
    localparam int TS_BITS  = 32;
    localparam int CNT_BITS = 16;

    // Field widths fixed by the interface
    localparam int TARGET_BITS  = 16;
    localparam int PPR_BITS     = 16;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DAT_BITS = 16;
    localparam int SPEED_BITS   = 32;

    // rpm = count * 600e6 * 256 / (elapsed * ppr)
    localparam int RPM_BITS = 30;
    localparam int Q8_BITS  = 8;
    localparam logic [RPM_BITS-1:0] RPM_SCALE = 30'd600000000;

    localparam int PROD_BITS = CNT_BITS + RPM_BITS;
    localparam int NUM_BITS  = PROD_BITS + Q8_BITS;
    localparam int DEN_BITS  = TS_BITS + PPR_BITS;
    localparam int STEP_BITS = $clog2(NUM_BITS);

    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_COUNT = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PPR          = 1'd1;

    // Input opcodes and end causes
    localparam logic OP_EDGE       = 1'b0;
    localparam logic OP_TIMEOUT    = 1'b1;
    localparam logic CAUSE_TARGET  = 1'b0;
    localparam logic CAUSE_TIMEOUT = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] edge_time;
    } in_word_t;

    typedef struct packed {
        logic [15:0] periods_used;
        logic [31:0] elapsed_ticks;
        logic        end_cause;
        logic [31:0] speed_rpm_q8;
    } out_word_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic accept;    // input word taken this cycle
        logic mul_load;  // register numerator and denominator
        logic div_step;  // one restoring division step
        logic out_load;  // load result into output register
    } dp_cmd_t;

    typedef struct packed {
        logic pub_req;   // presented word closes a window
        logic den_zero;  // denominator is zero, hold speed
        logic out_free;  // output register can take a word
    } dp_status_t;

endpackage

FILE: sv/wtach_ctrl.sv
// Controller FSM of the windowed tachometer: sequences accept, multiply,
// bit-serial divide and result load. Depends on wtach_pkg.
module wtach_ctrl
    import wtach_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output state_t     state
);

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid && status.pub_req)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (status.den_zero)
                    state_next = S_OUT;
                else
                begin
                    cmd.div_step = 1'b1;
                    if (step_reg == STEP_BITS'(NUM_BITS - 1))
                        state_next = S_OUT;
                    else
                        step_next = step_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

FILE: sv/wtach_dp.sv
// Datapath of the windowed tachometer: config registers, window state,
// multiplier, restoring divider and output register. Depends on wtach_pkg.
module wtach_dp
    import wtach_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_DAT_BITS-1:0] cfg_data,
    input  in_word_t                in_word,
    output out_word_t               out_word,
    output logic                    out_valid,
    input  logic                    out_stall,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status
);

    // Config
    logic [TARGET_BITS-1:0] target_reg, target_next;
    logic [PPR_BITS-1:0]    ppr_reg, ppr_next;

    // Window state
    logic                armed_reg, armed_next;
    logic                running_reg, running_next;
    logic [TS_BITS-1:0]  start_reg, start_next;
    logic [TS_BITS-1:0]  last_reg, last_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [SPEED_BITS-1:0] held_reg, held_next;

    // Published window, arithmetic, output
    logic [CNT_BITS-1:0] pcount_reg, pcount_next;
    logic [TS_BITS-1:0]  pelapsed_reg, pelapsed_next;
    logic                pcause_reg, pcause_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [NUM_BITS-1:0] nq_reg, nq_next;
    out_word_t           out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [TS_BITS-1:0]    t_in;
    logic [CNT_BITS-1:0]   count_inc;
    logic                  edge_close;
    logic                  tmo_close;
    logic [PROD_BITS-1:0]  prod;
    logic [DEN_BITS:0]     trial;
    logic [DEN_BITS:0]     diff;
    logic                  ge;
    logic [SPEED_BITS-1:0] q_sat;
    logic [SPEED_BITS-1:0] speed;

    assign t_in      = in_word.edge_time[TS_BITS-1:0];
    assign count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
    assign edge_close = running_reg && (TARGET_BITS'(count_inc) >= target_reg);
    assign tmo_close  = running_reg && (count_reg != '0);

    assign prod  = PROD_BITS'(pcount_reg) * PROD_BITS'(RPM_SCALE);
    assign trial = {rem_reg, nq_reg[NUM_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});
    assign q_sat = (nq_reg[NUM_BITS-1:SPEED_BITS] != '0) ? {SPEED_BITS{1'b1}}
                                                        : nq_reg[SPEED_BITS-1:0];
    assign speed = (den_reg == '0) ? held_reg : q_sat;

    assign status.pub_req  = (in_word.opcode == OP_EDGE) ? edge_close : tmo_close;
    assign status.den_zero = (den_reg == '0);
    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        target_next    = target_reg;
        ppr_next       = ppr_reg;
        armed_next     = armed_reg;
        running_next   = running_reg;
        start_next     = start_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        held_next      = held_reg;
        pcount_next    = pcount_reg;
        pelapsed_next  = pelapsed_reg;
        pcause_next    = pcause_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        nq_next        = nq_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TARGET_COUNT: target_next = TARGET_BITS'(cfg_data);
                REG_PPR:          ppr_next    = PPR_BITS'(cfg_data);
                default:          ;
            endcase
        end

        if (cmd.accept)
        begin
            if (in_word.opcode == OP_EDGE)
            begin
                last_next = t_in;
                if (running_reg)
                begin
                    count_next = count_inc;
                    if (edge_close)
                    begin
                        running_next  = 1'b0;
                        armed_next    = 1'b1;
                        pcount_next   = count_inc;
                        pelapsed_next = t_in - start_reg;
                        pcause_next   = CAUSE_TARGET;
                    end
                end
                else if (armed_reg)
                begin
                    start_next   = t_in;
                    count_next   = '0;
                    running_next = 1'b1;
                    armed_next   = 1'b0;
                end
            end
            else if (tmo_close)
            begin
                running_next  = 1'b0;
                armed_next    = 1'b1;
                pcount_next   = count_reg;
                pelapsed_next = last_reg - start_reg;
                pcause_next   = CAUSE_TIMEOUT;
            end
        end

        if (cmd.mul_load)
        begin
            nq_next  = {prod, Q8_BITS'(0)};
            den_next = DEN_BITS'(pelapsed_reg) * DEN_BITS'(ppr_reg);
            rem_next = '0;
        end

        if (cmd.div_step)
        begin
            rem_next = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            nq_next  = {nq_reg[NUM_BITS-2:0], ge};
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.out_load)
        begin
            held_next              = speed;
            out_next.periods_used  = 16'(pcount_reg);
            out_next.elapsed_ticks = 32'(pelapsed_reg);
            out_next.end_cause     = pcause_reg;
            out_next.speed_rpm_q8  = speed;
            out_valid_next         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= TARGET_BITS'(100);
            ppr_reg       <= PPR_BITS'(1);
            armed_reg     <= 1'b1;
            running_reg   <= 1'b0;
            start_reg     <= '0;
            last_reg      <= '0;
            count_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            target_reg    <= target_next;
            ppr_reg       <= ppr_next;
            armed_reg     <= armed_next;
            running_reg   <= running_next;
            start_reg     <= start_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pcount_reg   <= pcount_next;
        pelapsed_reg <= pelapsed_next;
        pcause_reg   <= pcause_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        nq_reg       <= nq_next;
        out_reg      <= out_next;
    end

    assign out_word  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

FILE: sv/windowed_tachometer_core.sv
// Top level of the windowed tachometer (reciprocal frequency counter).
// Instantiates wtach_ctrl and wtach_dp; depends on wtach_pkg.
//
// Each input word is a rising edge with its 10 MHz capture time, or a
// timeout tick. An armed edge opens a window; later edges are counted until
// target_count is reached, or a timeout closes a window holding at least one
// period. A closed window yields one output word: period count, elapsed
// ticks (wrap-safe), end cause and speed in rpm, unsigned Q24.8, computed as
// count*600e6*256/(elapsed*ppr), ppr being the periods-per-revolution
// register, and saturated to 32 bits; with a zero denominator the previous
// speed repeats. A word that closes no window is taken straight from idle.
// A closing word goes through accept, multiply, 54 steps of the
// bit-serial restoring divider (one quotient bit a cycle; a zero denominator
// skips the steps) and a load of the output register; the load waits
// while a previous result is still stalled. in_stall is high from the
// multiply until the load. Config writes are always ready and are
// meant for when the block is idle.
module windowed_tachometer_core
    import wtach_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input words
    input  logic                    in_valid,
    output logic                    in_stall,
    input  in_word_t                in_word,
    // result words
    output logic                    out_valid,
    input  logic                    out_stall,
    output out_word_t               out_word,
    // config writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_DAT_BITS-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;
    state_t     state;

    assign cfg_ready = 1'b1;

    wtach_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    wtach_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .out_word  (out_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // A closing word must take the controller out of idle.
    a_pub_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && status.pub_req) |=> in_stall)
        else $error("closing word did not start computation");

    // A new result appears only from the load state.
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> ($past(state) == S_OUT))
        else $error("result appeared outside load state");

    // Result load never overwrites a stalled word.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result overwrote a pending word");

endmodule

FILE: test/windowed_tachometer_core_tb.sv
// Self-checking testbench for windowed_tachometer_core.
// Depends on wtach_pkg and the RTL. A scoreboard class tracks the windows and
// holds the expected result words; plain tasks drive the input and config ports.
module windowed_tachometer_core_tb;
    import wtach_pkg::*;

    // 600e6 rpm*ticks per period, times 256 for the Q24.8 fraction
    localparam logic [63:0] RPM_TICKS_Q8 = 64'd600_000_000 * 64'd256;
    // margin for the block to settle after its longest internal work on one word
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 6;
    localparam int PHASE_WORDS    = 205;
    localparam int SHOW_LIMIT     = 10;

    // Tracks the open window exactly as the block should, and keeps one
    // expected result word per closed window, oldest first.
    class window_board;
        logic [15:0] target_count;
        logic [15:0] ppr;
        logic        armed;
        logic        running;
        logic [31:0] start_time;
        logic [31:0] last_time;
        logic [15:0] periods;
        logic [31:0] held_rpm;
        out_word_t   closed_windows[$];
        int          errors;
        int          shown;

        function new();
            target_count   = 16'd100;
            ppr            = 16'd1;
            armed          = 1'b1;
            running        = 1'b0;
            start_time     = '0;
            last_time      = '0;
            periods        = '0;
            held_rpm       = '0;
            errors         = 0;
            shown          = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DAT_BITS-1:0] data);
            if (idx == REG_TARGET_COUNT)
                target_count = data;
            else if (idx == REG_PPR)
                ppr = data;
        endfunction

        // Closes the window: speed from the exact 64-bit quotient, held on a
        // zero denominator, then re-arm.
        function void close_window(logic cause);
            out_word_t   closed;
            logic [31:0] elapsed;
            logic [63:0] den;
            logic [63:0] quot;
            elapsed = last_time - start_time;
            den = {32'd0, elapsed} * {48'd0, ppr};
            if (den != 0)
            begin
                quot = ({48'd0, periods} * RPM_TICKS_Q8) / den;
                held_rpm = (quot > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
            end
            closed.periods_used  = periods;
            closed.elapsed_ticks = elapsed;
            closed.end_cause     = cause;
            closed.speed_rpm_q8  = held_rpm;
            closed_windows.push_back(closed);
            running = 1'b0;
            armed   = 1'b1;
        endfunction

        function void note_input(in_word_t w);
            if (w.opcode == OP_TIMEOUT)
            begin
                if (running && periods != 0)
                    close_window(CAUSE_TIMEOUT);
                return;
            end
            last_time = w.edge_time;
            if (running)
            begin
                if (periods != CNT_MAX)
                    periods++;
                if (periods >= target_count)
                    close_window(CAUSE_TARGET);
            end
            else if (armed)
            begin
                start_time = w.edge_time;
                periods    = '0;
                running    = 1'b1;
                armed      = 1'b0;
            end
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            logic      bad;
            if (closed_windows.size() == 0)
            begin
                errors++;
                if (shown < SHOW_LIMIT)
                begin
                    shown++;
                    $display("unexpected result word: cnt=%0d ela=%h cause=%0d rpm=%h",
                             got.periods_used, got.elapsed_ticks, got.end_cause,
                             got.speed_rpm_q8);
                end
                return;
            end
            want = closed_windows.pop_front();
            bad = (got.periods_used !== want.periods_used)
                | (got.elapsed_ticks !== want.elapsed_ticks)
                | (got.end_cause !== want.end_cause)
                | (got.speed_rpm_q8 !== want.speed_rpm_q8);
            if (bad)
            begin
                errors++;
                if (shown < SHOW_LIMIT)
                begin
                    shown++;
                    $display("mismatch: expected cnt=%0d ela=%h cause=%0d rpm=%h",
                             want.periods_used, want.elapsed_ticks, want.end_cause,
                             want.speed_rpm_q8);
                    $display("          actual   cnt=%0d ela=%h cause=%0d rpm=%h",
                             got.periods_used, got.elapsed_ticks, got.end_cause,
                             got.speed_rpm_q8);
                end
            end
        endfunction
    endclass

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    in_word_t                in_word   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    out_word_t               out_word;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DAT_BITS-1:0] cfg_data  = '0;

    window_board board;

    // idle rates in percent; bursts give stretches with no idling at all
    int send_pct    = 0;
    int stall_pct   = 0;
    int send_burst  = 0;
    int stall_burst = 0;
    int quiet       = 0;

    windowed_tachometer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word (out_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    // Receiver: stall decided at the falling edge, never tied to out_valid.
    always @(negedge clk)
    begin
        if (stall_burst > 0)
        begin
            stall_burst <= stall_burst - 1;
            out_stall   <= 1'b0;
        end
        else if ($urandom_range(99) < 2)
        begin
            stall_burst <= $urandom_range(30, 5);
            out_stall   <= 1'b0;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result words are taken at the rising edge and checked in order.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_word);
    end

    // Watchdog: any cycle that moves a word on any channel clears the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet <= 0;
            else if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    // Presents one word after an optional random gap and holds it until taken.
    task automatic send_word(input logic op, input logic [31:0] stamp);
        in_word_t w;
        w.opcode    = op;
        w.edge_time = stamp;
        @(negedge clk);
        forever
        begin
            if (send_burst > 0)
            begin
                send_burst--;
                break;
            end
            if ($urandom_range(99) < 2)
            begin
                send_burst = $urandom_range(30, 5);
                break;
            end
            if ($urandom_range(99) >= send_pct)
                break;
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(w);
    endtask

    // Drops valid, waits for every pending window, then lets the block settle
    // since a word that closes nothing may still be in flight.
    task automatic drain_and_pause();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.closed_windows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DAT_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed edge trains with random spacing, some timeouts and
    // some edges at arbitrary times. Spacing ranges from zero to full wraps.
    task automatic run_phase(input int p);
        logic [31:0] stamp;
        int          r;
        stamp = $urandom;
        for (int i = 0; i < PHASE_WORDS; i++)
        begin
            // sender holds back once until every window has come out
            if (p == 1 && i == PHASE_WORDS / 2)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (board.closed_windows.size() != 0)
                    @(posedge clk);
            end
            r = $urandom_range(99);
            if (r < 80)
            begin
                case ($urandom_range(3))
                    0: stamp += $urandom_range(15);
                    1: stamp += $urandom_range(4095);
                    2: stamp += $urandom_range(1 << 20);
                    default: stamp += $urandom;
                endcase
                send_word(OP_EDGE, stamp);
            end
            else if (r < 92)
                send_word(OP_TIMEOUT, $urandom);
            else
            begin
                stamp = $urandom;
                send_word(OP_EDGE, stamp);
            end
        end
    endtask

    initial
    begin
        logic [31:0] stamp;
        int          mode;
        board = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed part, reset config: target 100, one pulse per rev ---
        send_word(OP_TIMEOUT, 32'hFFFF_FFFF);  // armed, not running: nothing
        send_word(OP_EDGE, 32'hFFFF_FFF0);     // opens window
        send_word(OP_TIMEOUT, 32'h0000_0000);  // running, zero count: nothing
        send_word(OP_EDGE, 32'h0000_0010);     // count 1 across the wrap
        send_word(OP_TIMEOUT, 32'h5555_5555);  // closes; speed saturates
        send_word(OP_EDGE, 32'h0000_0000);
        send_word(OP_EDGE, 32'h0000_0000);     // zero elapsed
        send_word(OP_TIMEOUT, 32'hAAAA_AAAA);  // speed held
        drain_and_pause();

        // target zero: first counted edge closes; widest ppr gives zero rpm
        write_reg(REG_TARGET_COUNT, 16'd0);
        write_reg(REG_PPR, 16'hFFFF);
        send_word(OP_EDGE, 32'hFFFF_FFFF);
        send_word(OP_EDGE, 32'h7FFF_FFFF);
        drain_and_pause();

        // zero ppr holds speed; target lowered while a window is open
        write_reg(REG_TARGET_COUNT, 16'd5);
        write_reg(REG_PPR, 16'd0);
        send_word(OP_EDGE, 32'd1000);
        send_word(OP_EDGE, 32'd2000);
        send_word(OP_EDGE, 32'd3000);
        send_word(OP_EDGE, 32'd4000);
        drain_and_pause();
        write_reg(REG_TARGET_COUNT, 16'd2);
        send_word(OP_EDGE, 32'd5000);          // count 4 already past target
        drain_and_pause();

        write_reg(REG_TARGET_COUNT, 16'd3);
        write_reg(REG_PPR, 16'd1);
        send_word(OP_EDGE, 32'h1234_5678);
        send_word(OP_EDGE, 32'h1234_9ABC);
        send_word(OP_EDGE, 32'h1235_0000);
        send_word(OP_EDGE, 32'h1236_0001);     // closes on target
        drain_and_pause();

        // largest target: a window of back-to-back edges closed by a timeout
        write_reg(REG_TARGET_COUNT, 16'hFFFF);
        write_reg(REG_PPR, 16'd7);
        stamp = $urandom;
        send_word(OP_EDGE, stamp);
        for (int i = 0; i < 20; i++)
        begin
            stamp += $urandom_range(40000);
            send_word(OP_EDGE, stamp);
        end
        send_word(OP_TIMEOUT, $urandom);
        drain_and_pause();

        // --- random phases: no idling, sender, receiver, both ---
        for (int p = 0; p < PHASES; p++)
        begin
            mode = p % 4;
            send_pct  = (mode == 1) ? 59 : (mode == 3) ? 13 : 0;
            stall_pct = (mode == 2) ? 59 : (mode == 3) ? 13 : 0;
            case (p)
                0: begin
                    write_reg(REG_TARGET_COUNT, 16'd1);
                    write_reg(REG_PPR, 16'd1);
                end
                2: begin
                    write_reg(REG_TARGET_COUNT, 16'd3);
                    write_reg(REG_PPR, 16'd0);
                end
                3: begin
                    write_reg(REG_TARGET_COUNT, 16'($urandom_range(12, 1)));
                    write_reg(REG_PPR, 16'hFFFF);
                end
                default: begin
                    write_reg(REG_TARGET_COUNT, 16'($urandom_range(8, 2)));
                    write_reg(REG_PPR, 16'($urandom_range(400, 1)));
                end
            endcase
            run_phase(p);
            drain_and_pause();
        end

        if (board.errors == 0 && board.closed_windows.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
